// File: hdl/itr_pkg.sv
`timescale 1ns / 1ps
package itr_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_RADIX_DEF  = 36;

  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] DECIMAL_RADIX = 6'd10;

  localparam logic [CHAR_W-1:0] CH_MINUS    = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0] CH_NINE     = 7'h39;
  localparam logic [CHAR_W-1:0] CH_LETTER_A = 7'h41;
  localparam logic [CHAR_W-1:0] CH_LETTER_Z = 7'h5A;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store_digit;
    logic push_sign;
    logic push_digit;
  } itr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bit_last;
    logic quo_zero;
    logic count_full;
    logic count_one;
    logic sign_neg;
    logic out_free;
  } itr_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    if (d < DECIMAL_RADIX) begin
      return CH_ZERO + dx;
    end
    return CH_LETTER_A + dx - CHAR_W'(DECIMAL_RADIX);
  endfunction

endpackage

// File: hdl/itr_ctrl.sv
`timescale 1ns / 1ps
module itr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  itr_pkg::itr_sts_t sts,
  output itr_pkg::itr_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_STORE = 6'b000100,
    S_SIGN  = 6'b001000,
    S_READ  = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.bit_last) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store_digit = 1'b1;
        if (sts.quo_zero || sts.count_full) begin
          state_nxt = sts.sign_neg ? S_SIGN : S_READ;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_SIGN: begin
        // read data for the top digit settles while the sign goes out
        if (sts.out_free) begin
          cmd.push_sign = 1'b1;
          state_nxt     = S_PUSH;
        end
      end
      S_READ: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push_digit = 1'b1;
          state_nxt      = sts.count_one ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/itr_dpath.sv
`timescale 1ns / 1ps
module itr_dpath #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = itr_pkg::MAX_RADIX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [VALUE_BITS-1:0]    in_number,
  input  logic [itr_pkg::RADIX_W-1:0]     in_radix,
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [itr_pkg::CHAR_W-1:0]      out_text_char,
  output logic                            out_last_char,
  input  itr_pkg::itr_cmd_t               cmd,
  output itr_pkg::itr_sts_t               sts
);

  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int DW    = itr_pkg::DIGIT_W;
  localparam int RW    = itr_pkg::RADIX_W;

  logic [VALUE_BITS-1:0]        quo_r, quo_nxt;
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [RW-1:0]                radix_r, radix_nxt;
  logic                         sign_r;
  logic [IDX_W-1:0]             bcnt_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [DW-1:0]                digit_mem [VALUE_BITS];
  logic [DW-1:0]                rd_data_r;
  logic [IDX_W-1:0]             rd_addr;
  logic                         out_valid_r;
  logic [itr_pkg::CHAR_W-1:0]   out_char_r;
  logic                         out_last_r;
  logic [DW:0]                  rem_sh;
  logic                         qbit;
  logic                         neg;
  logic [VALUE_BITS-1:0]        mag;

  // Clamp radix and fold the sign in for decimal only
  always_comb begin
    radix_nxt = in_radix;
    if (in_radix < itr_pkg::RADIX_MIN) begin
      radix_nxt = itr_pkg::RADIX_MIN;
    end else if (in_radix > RW'(MAX_RADIX)) begin
      radix_nxt = RW'(MAX_RADIX);
    end
    neg = in_number[VALUE_BITS-1] && (radix_nxt == itr_pkg::DECIMAL_RADIX);
    mag = neg ? (~in_number + 1'b1) : in_number;
  end

  // One restoring division step per cycle, quotient shifts in place
  always_comb begin
    rem_sh = {rem_r, quo_r[VALUE_BITS-1]};
    qbit   = (rem_sh >= {1'b0, radix_r});
    rem_nxt = qbit ? DW'(rem_sh - {1'b0, radix_r}) : DW'(rem_sh);
    quo_nxt = {quo_r[VALUE_BITS-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r   <= mag;
      radix_r <= radix_nxt;
      sign_r  <= neg;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end else if (cmd.store_digit) begin
      rem_r <= '0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.load) begin
      count_nxt = '0;
    end else if (cmd.store_digit) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.push_digit) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.div_step) begin
        bcnt_r <= (bcnt_r == IDX_W'(VALUE_BITS - 1)) ? '0 : bcnt_r + 1'b1;
      end else if (cmd.load) begin
        bcnt_r <= '0;
      end
    end
  end

  // Digit store, least significant digit at address zero
  assign rd_addr = IDX_W'(count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.store_digit) begin
      digit_mem[count_r[IDX_W-1:0]] <= rem_r;
    end
    rd_data_r <= digit_mem[rd_addr];
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_sign || cmd.push_digit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_sign) begin
      out_char_r <= itr_pkg::CH_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.push_digit) begin
      out_char_r <= itr_pkg::digit_char(rd_data_r);
      out_last_r <= (count_r == CNT_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_text_char = out_char_r;
  assign out_last_char = out_last_r;

  always_comb begin
    sts.bit_last   = (bcnt_r == IDX_W'(VALUE_BITS - 1));
    sts.quo_zero   = (quo_r == '0);
    sts.count_full = (count_r == CNT_W'(VALUE_BITS - 1));
    sts.count_one  = (count_r == CNT_W'(1));
    sts.sign_neg   = sign_r;
    sts.out_free   = !out_valid_r || !out_stall;
  end

endmodule

// File: hdl/integer_to_radix_text.sv
`timescale 1ns / 1ps
// Integer to radix text converter.
// Input channel (in_valid / in_stall): one word carries a signed number and a
// radix; radix values below 2 or above MAX_RADIX are clamped. Only radix 10
// shows a negative number as '-' and its magnitude; other radixes convert the
// two's complement pattern as unsigned.
// Output channel (out_valid / out_stall): one ASCII character per word, most
// significant digit first, out_last_char set on the final character. Zero
// gives the single character '0'.
// Conversion: each digit comes from a full pass of the bit-serial restoring
// divider into the digit store; each character is then read from the digit
// store and loaded into the output register, one after the other.
// A new number is taken only once the previous text has all been handed to
// the output register; the last character may still be waiting there.
// A stall on the output holds the current character and pauses emission.
// Reset clears the controller and the output valid; no clearing pass.
module integer_to_radix_text #(
  parameter int VALUE_BITS = itr_pkg::VALUE_BITS_DEF,
  parameter int MAX_RADIX  = itr_pkg::MAX_RADIX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [VALUE_BITS-1:0]    in_number,
  input  logic [itr_pkg::RADIX_W-1:0]     in_radix,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [itr_pkg::CHAR_W-1:0]      out_text_char,
  output logic                            out_last_char
);

  itr_pkg::itr_cmd_t cmd;
  itr_pkg::itr_sts_t sts;

  itr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itr_dpath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_RADIX  (MAX_RADIX)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_number     (in_number),
    .in_radix      (in_radix),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_text_char (out_text_char),
    .out_last_char (out_last_char),
    .cmd           (cmd),
    .sts           (sts)
  );

  // Busy right after taking a number
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

  // Sign never ends a text
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_text_char == itr_pkg::CH_MINUS) |-> !out_last_char)
    else $error("sign marked as last character");

  // Only sign, digits or upper-case letters leave the block
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_text_char == itr_pkg::CH_MINUS ||
                   (out_text_char >= itr_pkg::CH_ZERO &&
                    out_text_char <= itr_pkg::CH_NINE) ||
                   (out_text_char >= itr_pkg::CH_LETTER_A &&
                    out_text_char <= itr_pkg::CH_LETTER_Z)))
    else $error("character outside text set");

  // No character is pushed in the cycle a number is accepted
  a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !(cmd.push_sign || cmd.push_digit))
    else $error("character pushed while idle");

endmodule
